/* rtl/ild_pkg.sv */
// shared types, constants and helpers of the inverse lens distortion vertex block
`default_nettype none
package ild_pkg;

	localparam int MAX_ITERATIONS = 32;
	localparam int FRAC_W = 16;
	localparam int ITER_W = $clog2(MAX_ITERATIONS);

	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 32;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int MUL_DIGIT_W = 8;
	localparam int MUL_STEPS = MUL_B_W / MUL_DIGIT_W;

	localparam int SQ_IN_W = 40;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int DIV_D_W = 37;
	localparam int DIV_Q_W = 2 * FRAC_W + 1;

	localparam int INNER_W = 38;
	localparam logic signed [63:0] INNER_LIMIT = 64'sd1 <<< 36;
	localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 18) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 18);

	localparam logic [2:0] REG_K0 = 3'd0;
	localparam logic [2:0] REG_K1 = 3'd1;
	localparam logic [2:0] REG_K2 = 3'd2;
	localparam logic [2:0] REG_K3 = 3'd3;
	localparam logic [2:0] REG_LENS_OFFSET = 3'd4;
	localparam logic [2:0] REG_EYE_ASPECT = 3'd5;
	localparam logic [2:0] REG_INV_EYE_ASPECT = 3'd6;
	localparam logic [2:0] REG_TOLERANCE = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RY, ST_RXSQ, ST_RYSQ, ST_SQRT, ST_MID, ST_MIDSQ,
		ST_H2, ST_H1, ST_H0, ST_GOT, ST_CHECK, ST_DIV, ST_OX, ST_OYA, ST_OYB, ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	// product scaled down by the fraction bits, truncated toward zero
	function automatic logic signed [63:0] fx_shift(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] q;
		q = p >>> FRAC_W;
		if (p[PROD_W-1] && (|p[FRAC_W-1:0]))
			q = q + PROD_W'(1);
		return q[63:0];
	endfunction

	function automatic logic signed [INNER_W-1:0] clamp_inner(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > INNER_LIMIT)
			c = INNER_LIMIT;
		else if (v < -INNER_LIMIT)
			c = -INNER_LIMIT;
		return c[INNER_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/ild_mul.sv */
// shared signed multiplier, one eight-bit digit of the second operand per cycle
`default_nettype none
module ild_mul (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ild_pkg::mul_req_t req,
	output ild_pkg::mul_rsp_t rsp
);

	logic signed [ild_pkg::MUL_A_W-1:0] a_q;
	logic [ild_pkg::MUL_B_W-1:0] bmag_q;
	logic neg_q;
	logic signed [ild_pkg::PROD_W-1:0] acc_q;
	logic [$clog2(ild_pkg::MUL_STEPS)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ild_pkg::MUL_B_W-1:0] bneg;
	logic signed [ild_pkg::MUL_A_W+ild_pkg::MUL_DIGIT_W:0] pp;

	assign bneg = ild_pkg::MUL_B_W'(-req.b);
	assign pp = a_q * $signed({1'b0, bmag_q[ild_pkg::MUL_B_W-1 -: ild_pkg::MUL_DIGIT_W]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(ild_pkg::MUL_STEPS))'(ild_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			bmag_q <= req.b[ild_pkg::MUL_B_W-1] ? bneg : req.b;
			neg_q <= req.b[ild_pkg::MUL_B_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< ild_pkg::MUL_DIGIT_W)
				+ {{(ild_pkg::PROD_W-ild_pkg::MUL_A_W-ild_pkg::MUL_DIGIT_W-1){pp[$high(pp)]}}, pp};
			bmag_q <= bmag_q << ild_pkg::MUL_DIGIT_W;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = neg_q ? -acc_q : acc_q;

endmodule
`default_nettype wire

/* rtl/ild_sqrt.sv */
// integer square root, two radicand bits per cycle
`default_nettype none
module ild_sqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [ild_pkg::SQ_IN_W-1:0] radicand,
	output logic done,
	output logic [ild_pkg::SQ_OUT_W-1:0] root
);

	logic [ild_pkg::SQ_IN_W-1:0] v_q;
	logic [ild_pkg::SQ_OUT_W+2:0] rem_q;
	logic [ild_pkg::SQ_OUT_W-1:0] root_q;
	logic [$clog2(ild_pkg::SQ_OUT_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ild_pkg::SQ_OUT_W+2:0] rem_sh;
	logic [ild_pkg::SQ_OUT_W+2:0] trial;

	assign rem_sh = {rem_q[ild_pkg::SQ_OUT_W:0], v_q[ild_pkg::SQ_IN_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(ild_pkg::SQ_OUT_W))'(ild_pkg::SQ_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[ild_pkg::SQ_OUT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[ild_pkg::SQ_OUT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* rtl/ild_div.sv */
// restoring divider for the reciprocal of the scale, one quotient bit per cycle
`default_nettype none
module ild_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [ild_pkg::DIV_D_W-1:0] divisor,
	output logic done,
	output logic [ild_pkg::DIV_Q_W-1:0] quotient
);

	logic [ild_pkg::DIV_Q_W-1:0] dvd_q;
	logic [ild_pkg::DIV_D_W-1:0] d_q;
	logic [ild_pkg::DIV_D_W-1:0] rem_q;
	logic [ild_pkg::DIV_Q_W-1:0] q_q;
	logic [$clog2(ild_pkg::DIV_Q_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ild_pkg::DIV_D_W:0] rem_sh;
	logic [ild_pkg::DIV_D_W:0] rem_sub;

	assign rem_sh = {rem_q, dvd_q[ild_pkg::DIV_Q_W-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(ild_pkg::DIV_Q_W))'(ild_pkg::DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend is one in Q.32, a single set top bit
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b1, {(ild_pkg::DIV_Q_W-1){1'b0}}};
			d_q <= divisor;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sub[ild_pkg::DIV_D_W-1:0];
				q_q <= {q_q[ild_pkg::DIV_Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[ild_pkg::DIV_D_W-1:0];
				q_q <= {q_q[ild_pkg::DIV_Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = q_q;

endmodule
`default_nettype wire

/* rtl/inverse_lens_distort_vertex.sv */
// top level: config registers, sequencer and datapath of the inverse lens distortion
// Inverse radial lens distortion of one mesh vertex.
// Input channel (in_valid/in_ready) carries pos_x, pos_y (signed Q2.16) and eye.
// Output channel (out_valid/out_ready) carries out_x, out_y (signed Q3.16),
// not_converged and saturated; one result per input transfer.
// Registers are written through wr_en/wr_index/wr_data; the user must write them
// only while idle; the block itself does not enforce this. The bisection tries up to
// 32 midpoints and stops at the first that meets the tolerance; a zero scale skips
// the divider. Each bisection step runs five products through the shared multiplier,
// which retires eight bits of its second operand per cycle; the square root comes
// before the bisection and the reciprocal divider after it. in_ready is high only
// while the sequencer is idle, so an item is taken only after the last one has
// reached the output register.
// Results sit in an output register; the next item is taken while it waits. If the
// receiver stalls, a finished item holds in the last state until the register frees.
// Reset restores the register defaults and empties the output register.
`default_nettype none
module inverse_lens_distort_vertex (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [17:0] pos_x,
	input  wire logic signed [17:0] pos_y,
	input  wire logic eye,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [18:0] out_x,
	output logic signed [18:0] out_y,
	output logic not_converged,
	output logic saturated,
	input  wire logic wr_en,
	input  wire logic [2:0] wr_index,
	input  wire logic [19:0] wr_data
);

	logic signed [19:0] k0_q, k1_q, k2_q, k3_q;
	logic signed [17:0] lens_offset_q;
	logic [16:0] eye_aspect_q;
	logic [17:0] inv_eye_aspect_q;
	logic [15:0] tolerance_q;

	ild_pkg::state_t state_q, state_d;
	logic pend_q;

	logic signed [18:0] off_q;
	logic signed [18:0] rx_q;
	logic signed [17:0] py_q;
	logic signed [19:0] ry_q;
	logic [39:0] sumsq_q;
	logic [19:0] r_q;
	logic [20:0] lo_q, hi_q, mid_q;
	logic [25:0] rsq_q;
	logic signed [ild_pkg::INNER_W-1:0] t_q;
	logic signed [42:0] got_q;
	logic [ild_pkg::ITER_W-1:0] iter_q;
	logic nc_q;
	logic signed [ild_pkg::INNER_W-1:0] inv_q;
	logic signed [40:0] ox_q;
	logic signed [40:0] t1_q;
	logic signed [41:0] oy_q;

	logic signed [18:0] out_x_q, out_y_q;
	logic nc_out_q, sat_out_q, out_valid_q;

	ild_pkg::mul_req_t mul_req;
	ild_pkg::mul_rsp_t mul_rsp;
	logic sq_start, sq_done;
	logic [ild_pkg::SQ_OUT_W-1:0] sq_root;
	logic div_start, div_done;
	logic [ild_pkg::DIV_Q_W-1:0] div_q;

	logic mul_state;
	logic signed [63:0] fx;
	logic signed [18:0] off_in;
	logic signed [43:0] diff;
	logic [43:0] adiff;
	logic conv;
	logic [20:0] mid_d;
	logic [ild_pkg::INNER_W-1:0] tmag;
	logic out_free;
	logic signed [63:0] ox_w, oy_w;
	logic signed [63:0] cx, cy;

	assign in_ready = (state_q == ild_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign fx = ild_pkg::fx_shift(mul_rsp.prod);
	assign off_in = eye ? 19'(lens_offset_q) : -19'(lens_offset_q);
	assign diff = 44'(got_q) - 44'(signed'({1'b0, r_q}));
	assign adiff = diff[43] ? 44'(-diff) : 44'(diff);
	assign conv = adiff < 44'(tolerance_q);
	assign mid_d = lo_q + ((hi_q - lo_q) >> 1);
	assign tmag = t_q[ild_pkg::INNER_W-1] ? ild_pkg::INNER_W'(-t_q) : ild_pkg::INNER_W'(t_q);
	assign ox_w = 64'(ox_q);
	assign oy_w = 64'(oy_q);
	assign cx = (ox_w > ild_pkg::OUT_MAX) ? ild_pkg::OUT_MAX
		: ((ox_w < ild_pkg::OUT_MIN) ? ild_pkg::OUT_MIN : ox_w);
	assign cy = (oy_w > ild_pkg::OUT_MAX) ? ild_pkg::OUT_MAX
		: ((oy_w < ild_pkg::OUT_MIN) ? ild_pkg::OUT_MIN : oy_w);

	ild_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.rsp(mul_rsp)
	);

	ild_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(sumsq_q),
		.done(sq_done),
		.root(sq_root)
	);

	ild_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.divisor(tmag[ild_pkg::DIV_D_W-1:0]),
		.done(div_done),
		.quotient(div_q)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q <= 20'sd65536;
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			lens_offset_q <= '0;
			eye_aspect_q <= 17'd65536;
			inv_eye_aspect_q <= 18'd65536;
			tolerance_q <= 16'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				ild_pkg::REG_K0: k0_q <= wr_data;
				ild_pkg::REG_K1: k1_q <= wr_data;
				ild_pkg::REG_K2: k2_q <= wr_data;
				ild_pkg::REG_K3: k3_q <= wr_data;
				ild_pkg::REG_LENS_OFFSET: lens_offset_q <= wr_data[17:0];
				ild_pkg::REG_EYE_ASPECT: eye_aspect_q <= wr_data[16:0];
				ild_pkg::REG_INV_EYE_ASPECT: inv_eye_aspect_q <= wr_data[17:0];
				ild_pkg::REG_TOLERANCE: tolerance_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ild_pkg::ST_IDLE;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || sq_start || div_start)
				pend_q <= 1'b1;
			else if (mul_rsp.done || sq_done || div_done)
				pend_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_state = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		sq_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ild_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = ild_pkg::ST_RY;
			end
			ild_pkg::ST_RY: begin
				mul_state = 1'b1;
				mul_req.a = 48'(py_q);
				mul_req.b = 32'(signed'({1'b0, inv_eye_aspect_q}));
				if (mul_rsp.done)
					state_d = ild_pkg::ST_RXSQ;
			end
			ild_pkg::ST_RXSQ: begin
				mul_state = 1'b1;
				mul_req.a = 48'(rx_q);
				mul_req.b = 32'(rx_q);
				if (mul_rsp.done)
					state_d = ild_pkg::ST_RYSQ;
			end
			ild_pkg::ST_RYSQ: begin
				mul_state = 1'b1;
				mul_req.a = 48'(ry_q);
				mul_req.b = 32'(ry_q);
				if (mul_rsp.done)
					state_d = ild_pkg::ST_SQRT;
			end
			ild_pkg::ST_SQRT: begin
				sq_start = !pend_q;
				if (sq_done)
					state_d = ild_pkg::ST_MID;
			end
			ild_pkg::ST_MID: begin
				state_d = ild_pkg::ST_MIDSQ;
			end
			ild_pkg::ST_MIDSQ: begin
				mul_state = 1'b1;
				mul_req.a = 48'(signed'({1'b0, mid_q}));
				mul_req.b = 32'(signed'({1'b0, mid_q}));
				if (mul_rsp.done)
					state_d = ild_pkg::ST_H2;
			end
			ild_pkg::ST_H2, ild_pkg::ST_H1, ild_pkg::ST_H0: begin
				mul_state = 1'b1;
				mul_req.a = 48'(t_q);
				mul_req.b = 32'(signed'({1'b0, rsq_q}));
				if (mul_rsp.done) begin
					if (state_q == ild_pkg::ST_H2)
						state_d = ild_pkg::ST_H1;
					else if (state_q == ild_pkg::ST_H1)
						state_d = ild_pkg::ST_H0;
					else
						state_d = ild_pkg::ST_GOT;
				end
			end
			ild_pkg::ST_GOT: begin
				mul_state = 1'b1;
				mul_req.a = 48'(t_q);
				mul_req.b = 32'(signed'({1'b0, mid_q}));
				if (mul_rsp.done)
					state_d = ild_pkg::ST_CHECK;
			end
			ild_pkg::ST_CHECK: begin
				if (conv || iter_q == ild_pkg::ITER_W'(ild_pkg::MAX_ITERATIONS - 1))
					state_d = (t_q == '0) ? ild_pkg::ST_OX : ild_pkg::ST_DIV;
				else
					state_d = ild_pkg::ST_MID;
			end
			ild_pkg::ST_DIV: begin
				div_start = !pend_q;
				if (div_done)
					state_d = ild_pkg::ST_OX;
			end
			ild_pkg::ST_OX: begin
				mul_state = 1'b1;
				mul_req.a = 48'(inv_q);
				mul_req.b = 32'(rx_q);
				if (mul_rsp.done)
					state_d = ild_pkg::ST_OYA;
			end
			ild_pkg::ST_OYA: begin
				mul_state = 1'b1;
				mul_req.a = 48'(inv_q);
				mul_req.b = 32'(ry_q);
				if (mul_rsp.done)
					state_d = ild_pkg::ST_OYB;
			end
			ild_pkg::ST_OYB: begin
				mul_state = 1'b1;
				mul_req.a = 48'(t1_q);
				mul_req.b = 32'(signed'({1'b0, eye_aspect_q}));
				if (mul_rsp.done)
					state_d = ild_pkg::ST_FIN;
			end
			ild_pkg::ST_FIN: begin
				if (out_free)
					state_d = ild_pkg::ST_IDLE;
			end
			default: state_d = ild_pkg::ST_IDLE;
		endcase
		mul_req.start = mul_state && !pend_q;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ild_pkg::ST_IDLE: begin
				if (in_valid) begin
					off_q <= off_in;
					rx_q <= 19'(pos_x) + off_in;
					py_q <= pos_y;
				end
			end
			ild_pkg::ST_RY: if (mul_rsp.done) ry_q <= fx[19:0];
			ild_pkg::ST_RXSQ: if (mul_rsp.done) sumsq_q <= mul_rsp.prod[39:0];
			ild_pkg::ST_RYSQ: if (mul_rsp.done) sumsq_q <= sumsq_q + mul_rsp.prod[39:0];
			ild_pkg::ST_SQRT: begin
				if (sq_done) begin
					r_q <= sq_root;
					lo_q <= '0;
					hi_q <= {sq_root, 1'b0};
					iter_q <= '0;
				end
			end
			ild_pkg::ST_MID: begin
				mid_q <= mid_d;
				t_q <= ild_pkg::INNER_W'(k3_q);
			end
			ild_pkg::ST_MIDSQ: if (mul_rsp.done) rsq_q <= fx[25:0];
			ild_pkg::ST_H2: if (mul_rsp.done) t_q <= ild_pkg::clamp_inner(64'(k2_q) + fx);
			ild_pkg::ST_H1: if (mul_rsp.done) t_q <= ild_pkg::clamp_inner(64'(k1_q) + fx);
			ild_pkg::ST_H0: if (mul_rsp.done) t_q <= ild_pkg::clamp_inner(64'(k0_q) + fx);
			ild_pkg::ST_GOT: if (mul_rsp.done) got_q <= fx[42:0];
			ild_pkg::ST_CHECK: begin
				nc_q <= !conv;
				inv_q <= ild_pkg::INNER_W'(ild_pkg::INNER_LIMIT);
				if (!conv) begin
					if (diff[43])
						lo_q <= mid_q;
					else
						hi_q <= mid_q;
					iter_q <= iter_q + 1'b1;
				end
			end
			ild_pkg::ST_DIV: begin
				if (div_done)
					inv_q <= t_q[ild_pkg::INNER_W-1]
						? -ild_pkg::INNER_W'(div_q) : ild_pkg::INNER_W'(div_q);
			end
			ild_pkg::ST_OX: if (mul_rsp.done) ox_q <= 41'(fx) - 41'(off_q);
			ild_pkg::ST_OYA: if (mul_rsp.done) t1_q <= fx[40:0];
			ild_pkg::ST_OYB: if (mul_rsp.done) oy_q <= fx[41:0];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ild_pkg::ST_FIN && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ild_pkg::ST_FIN && out_free) begin
			out_x_q <= cx[18:0];
			out_y_q <= cy[18:0];
			nc_out_q <= nc_q;
			sat_out_q <= (cx != ox_w) || (cy != oy_w);
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign not_converged = nc_out_q;
	assign saturated = sat_out_q;

endmodule
`default_nettype wire

/* verif/tb_inverse_lens_distort_vertex.sv */
// self-checking testbench of the inverse lens distortion vertex block
`timescale 1ns / 1ps
`default_nettype none
module tb_inverse_lens_distort_vertex;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic eye;
	} vertex_t;

	typedef struct {
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic nc;
		logic sat;
	} warped_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [17:0] pos_x = '0;
	logic signed [17:0] pos_y = '0;
	logic eye = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [18:0] out_x;
	logic signed [18:0] out_y;
	logic not_converged;
	logic saturated;
	logic wr_en = 0;
	logic [2:0] wr_index = '0;
	logic [19:0] wr_data = '0;

	vertex_t pending_q[$];
	warped_t warped_q[$];
	longint coef[8];
	int errors = 0;
	bit calm = 0;
	int hold_cycles = 0;
	bit source_paused = 0;

	inverse_lens_distort_vertex i_dut (.*);

	initial forever #4 clk = ~clk;

	function automatic longint sx(longint v, int w);
		longint m;
		m = (longint'(1) << w) - 1;
		v = v & m;
		if (v >>> (w - 1))
			return v - (longint'(1) << w);
		return v;
	endfunction

	function automatic longint lim(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint fmul(longint a, longint b);
		return (a * b) / (longint'(1) << 16);
	endfunction

	function automatic longint root(longint v);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint lens_scale(longint rsq);
		longint t;
		t = coef[ild_pkg::REG_K3];
		t = lim(coef[ild_pkg::REG_K2] + fmul(rsq, t), -ild_pkg::INNER_LIMIT,
			ild_pkg::INNER_LIMIT);
		t = lim(coef[ild_pkg::REG_K1] + fmul(rsq, t), -ild_pkg::INNER_LIMIT,
			ild_pkg::INNER_LIMIT);
		t = lim(coef[ild_pkg::REG_K0] + fmul(rsq, t), -ild_pkg::INNER_LIMIT,
			ild_pkg::INNER_LIMIT);
		return t;
	endfunction

	function automatic warped_t undistort(vertex_t v);
		longint off, rx, ry, r, lo, hi, sc, inv, ox, oy, cx, cy, mid, got, d;
		bit hit;
		warped_t w;
		off = coef[ild_pkg::REG_LENS_OFFSET];
		if (!v.eye)
			off = -off;
		rx = longint'(v.x) + off;
		ry = fmul(longint'(v.y), coef[ild_pkg::REG_INV_EYE_ASPECT]);
		r = root(rx * rx + ry * ry);
		lo = 0;
		hi = 2 * r;
		sc = 0;
		hit = 0;
		for (int i = 0; i < ild_pkg::MAX_ITERATIONS; i++) begin
			mid = lo + (hi - lo) / 2;
			sc = lens_scale(fmul(mid, mid));
			got = fmul(sc, mid);
			d = got - r;
			if (d < 0)
				d = -d;
			if (d < coef[ild_pkg::REG_TOLERANCE]) begin
				hit = 1;
				break;
			end
			if (got < r)
				lo = mid;
			else
				hi = mid;
		end
		if (sc == 0) begin
			inv = ild_pkg::INNER_LIMIT;
		end else begin
			inv = (longint'(1) << 32) / (sc < 0 ? -sc : sc);
			if (sc < 0)
				inv = -inv;
			inv = lim(inv, -ild_pkg::INNER_LIMIT, ild_pkg::INNER_LIMIT);
		end
		ox = fmul(rx, inv) - off;
		oy = fmul(fmul(ry, inv), coef[ild_pkg::REG_EYE_ASPECT]);
		cx = lim(ox, ild_pkg::OUT_MIN, ild_pkg::OUT_MAX);
		cy = lim(oy, ild_pkg::OUT_MIN, ild_pkg::OUT_MAX);
		w.x = cx[18:0];
		w.y = cy[18:0];
		w.nc = !hit;
		w.sat = (cx != ox) || (cy != oy);
		return w;
	endfunction

	task automatic write_reg(logic [2:0] idx, longint val);
		@(posedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val[19:0];
		@(posedge clk);
		wr_en <= 0;
		case (idx)
			ild_pkg::REG_K0, ild_pkg::REG_K1, ild_pkg::REG_K2, ild_pkg::REG_K3:
				coef[idx] = sx(val, 20);
			ild_pkg::REG_LENS_OFFSET: coef[idx] = sx(val, 18);
			ild_pkg::REG_EYE_ASPECT: coef[idx] = val & 'h1FFFF;
			ild_pkg::REG_INV_EYE_ASPECT: coef[idx] = val & 'h3FFFF;
			default: coef[idx] = val & 'hFFFF;
		endcase
	endtask

	// checked away from the rising edge so that driver updates have settled
	task automatic drain();
		@(negedge clk);
		while (pending_q.size() != 0 || warped_q.size() != 0 || in_valid)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic push(logic signed [17:0] x, logic signed [17:0] y, logic e);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.eye = e;
		pending_q.insert(pending_q.size(), v);
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				push(18'($urandom), 18'($urandom), 1'($urandom));
			else
				push($signed(18'($urandom_range(0, 131072))) - 18'sd65536,
					$signed(18'($urandom_range(0, 131072))) - 18'sd65536,
					1'($urandom));
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			warped_q.insert(warped_q.size(), undistort('{pos_x, pos_y, eye}));
		end
		if (!in_valid || in_ready) begin
			if (pending_q.size() != 0 && !source_paused &&
					(calm || $urandom_range(0, 99) >= 29)) begin
				in_valid <= 1;
				pos_x <= pending_q[0].x;
				pos_y <= pending_q[0].y;
				eye <= pending_q[0].eye;
				void'(pending_q.pop_front());
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (warped_q.size() == 0) begin
				$error("unexpected transfer x=%0d y=%0d", out_x, out_y);
				errors++;
			end else begin
				if (out_x !== warped_q[0].x) begin
					$error("out_x expected %0d got %0d", warped_q[0].x, out_x);
					errors++;
				end
				if (out_y !== warped_q[0].y) begin
					$error("out_y expected %0d got %0d", warped_q[0].y, out_y);
					errors++;
				end
				if (not_converged !== warped_q[0].nc) begin
					$error("not_converged expected %0d got %0d", warped_q[0].nc,
						not_converged);
					errors++;
				end
				if (saturated !== warped_q[0].sat) begin
					$error("saturated expected %0d got %0d", warped_q[0].sat, saturated);
					errors++;
				end
				void'(warped_q.pop_front());
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 29);
		end
	end

	initial begin
		#60000000;
		$display("tb_inverse_lens_distort_vertex: done, errors");
		$finish;
	end

	initial begin
		coef[ild_pkg::REG_K0] = 65536;
		coef[ild_pkg::REG_K1] = 0;
		coef[ild_pkg::REG_K2] = 0;
		coef[ild_pkg::REG_K3] = 0;
		coef[ild_pkg::REG_LENS_OFFSET] = 0;
		coef[ild_pkg::REG_EYE_ASPECT] = 65536;
		coef[ild_pkg::REG_INV_EYE_ASPECT] = 65536;
		coef[ild_pkg::REG_TOLERANCE] = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed corners at reset settings
		push(18'sh1FFFF, 18'sh1FFFF, 1'b1);
		push(-18'sh20000, -18'sh20000, 1'b0);
		push('0, '0, 1'b0);
		push('0, '0, 1'b1);
		push(18'sd65536, '0, 1'b1);
		push('0, -18'sd65536, 1'b0);
		push(18'sd32768, 18'sd16384, 1'b1);
		drain();

		// typical barrel lens
		write_reg(ild_pkg::REG_K0, 65536);
		write_reg(ild_pkg::REG_K1, 14418);
		write_reg(ild_pkg::REG_K2, 15073);
		write_reg(ild_pkg::REG_K3, 2000);
		write_reg(ild_pkg::REG_LENS_OFFSET, 9500);
		write_reg(ild_pkg::REG_EYE_ASPECT, 52428);
		write_reg(ild_pkg::REG_INV_EYE_ASPECT, 81920);
		write_reg(ild_pkg::REG_TOLERANCE, 64);
		push(18'sh1FFFF, 18'sh1FFFF, 1'b0);
		push(-18'sh20000, 18'sh1FFFF, 1'b1);
		push('0, '0, 1'b0);
		push(-18'sd9500, '0, 1'b1);
		push(18'sd9500, '0, 1'b0);
		// long receiver hold-off while the source keeps offering
		hold_cycles <= 3000;
		push_random(10);
		drain();
		source_paused = 1;
		repeat (50) @(posedge clk);
		source_paused = 0;
		calm = 1;
		push_random(60);
		drain();
		calm = 0;
		push_random(150);
		drain();

		// zero scale, zero tolerance, zero aspects
		write_reg(ild_pkg::REG_K0, 0);
		write_reg(ild_pkg::REG_K1, 0);
		write_reg(ild_pkg::REG_K2, 0);
		write_reg(ild_pkg::REG_K3, 0);
		write_reg(ild_pkg::REG_TOLERANCE, 0);
		write_reg(ild_pkg::REG_EYE_ASPECT, 0);
		write_reg(ild_pkg::REG_INV_EYE_ASPECT, 0);
		push('0, '0, 1'b1);
		push(18'sd1000, 18'sd1000, 1'b0);
		push_random(20);
		drain();

		// extremes
		write_reg(ild_pkg::REG_K0, 'h80000);
		write_reg(ild_pkg::REG_K1, 'h7FFFF);
		write_reg(ild_pkg::REG_K2, 'h80000);
		write_reg(ild_pkg::REG_K3, 'h7FFFF);
		write_reg(ild_pkg::REG_LENS_OFFSET, 'h20000);
		write_reg(ild_pkg::REG_EYE_ASPECT, 'h1FFFF);
		write_reg(ild_pkg::REG_INV_EYE_ASPECT, 'h3FFFF);
		write_reg(ild_pkg::REG_TOLERANCE, 'hFFFF);
		push(18'sh1FFFF, -18'sh20000, 1'b0);
		push_random(60);
		drain();
		write_reg(ild_pkg::REG_K0, 'h7FFFF);
		write_reg(ild_pkg::REG_K1, 'h80000);
		write_reg(ild_pkg::REG_K2, 'h7FFFF);
		write_reg(ild_pkg::REG_K3, 'h80000);
		write_reg(ild_pkg::REG_LENS_OFFSET, 'h1FFFF);
		write_reg(ild_pkg::REG_EYE_ASPECT, 1);
		write_reg(ild_pkg::REG_INV_EYE_ASPECT, 1);
		write_reg(ild_pkg::REG_TOLERANCE, 1);
		push_random(40);
		drain();

		// random settings phases
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ild_pkg::REG_K0, $urandom);
			write_reg(ild_pkg::REG_K1, $urandom);
			write_reg(ild_pkg::REG_K2, $urandom);
			write_reg(ild_pkg::REG_K3, $urandom);
			write_reg(ild_pkg::REG_LENS_OFFSET, $urandom);
			write_reg(ild_pkg::REG_EYE_ASPECT, $urandom);
			write_reg(ild_pkg::REG_INV_EYE_ASPECT, $urandom);
			write_reg(ild_pkg::REG_TOLERANCE, $urandom_range(0, 2000));
			push_random(50);
			drain();
		end

		if (errors == 0)
			$display("tb_inverse_lens_distort_vertex: done, clean");
		else
			$display("tb_inverse_lens_distort_vertex: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
